/* src/rpn_pkg.sv */
// Shared types and codes for the RPN stack calculator.
// Depends on nothing; every other file of the block refers to it by scoped names.

package rpn_pkg;

   localparam int WORD_W   = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   typedef logic signed [WORD_W-1:0]   word_type;
   typedef logic        [WORD_W-1:0]   uword_type;
   typedef logic        [ACTION_W-1:0] action_type;
   typedef logic        [STATUS_W-1:0] status_type;

   localparam action_type ACT_PUSH = 3'd0;
   localparam action_type ACT_ADD  = 3'd1;
   localparam action_type ACT_SUB  = 3'd2;
   localparam action_type ACT_MUL  = 3'd3;
   localparam action_type ACT_DIV  = 3'd4;
   localparam action_type ACT_POP  = 3'd5;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;
   localparam status_type ST_DIVZERO = 2'd3;

   localparam int DIV_STEPS   = WORD_W;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic load_above;
      logic load_below;
   } cell_ctrl_type;

endpackage

/* src/rpn_req_if.sv */
// Request channel of the RPN stack calculator: one action and its operand.
// Depends on rpn_pkg for the field types.

interface rpn_req_if;
   logic                valid;
   logic                ready;
   rpn_pkg::action_type action;
   rpn_pkg::word_type   operand_value;

   modport source (output valid, output action, output operand_value, input ready);
   modport sink   (input valid, input action, input operand_value, output ready);
endinterface

/* src/rpn_rsp_if.sv */
// Response channel of the RPN stack calculator: popped value and status.
// Depends on rpn_pkg for the field types.

interface rpn_rsp_if;
   logic                valid;
   logic                ready;
   logic                result_valid;
   rpn_pkg::word_type   result_value;
   rpn_pkg::status_type status;

   modport source (output valid, output result_valid, output result_value, output status,
                   input ready);
   modport sink   (input valid, input result_valid, input result_value, input status,
                   output ready);
endinterface

/* src/rpn_cell.sv */
// One stack cell: holds one entry and loads from the cell above or below.
// Depends on rpn_pkg for the word and control types.

module rpn_cell (
   input  logic                  clock,
   input  rpn_pkg::cell_ctrl_type ctrl,
   input  rpn_pkg::word_type     above_value,
   input  rpn_pkg::word_type     below_value,
   output rpn_pkg::word_type     value
);

   rpn_pkg::word_type value_ff;
   rpn_pkg::word_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load_above) begin
         value_in = above_value;
      end else if (ctrl.load_below) begin
         value_in = below_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* src/rpn_divider.sv */
// Radix-2 restoring divider, signed operands, quotient truncated toward zero.
// Depends on rpn_pkg; the divisor must be nonzero when start is raised.

module rpn_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rpn_pkg::word_type dividend,
   input  rpn_pkg::word_type divisor,
   output logic              done,
   output rpn_pkg::word_type quotient
);

   localparam int W = rpn_pkg::WORD_W;

   logic [rpn_pkg::DIV_COUNT_W-1:0] count_ff, count_in;
   logic                            done_ff, done_in;
   rpn_pkg::uword_type              rem_ff, rem_in;
   rpn_pkg::uword_type              quo_ff, quo_in;
   rpn_pkg::uword_type              mb_ff, mb_in;
   logic                            neg_ff, neg_in;

   logic [W:0]         rem_shift;
   logic [W:0]         rem_diff;
   logic               ge;
   rpn_pkg::uword_type mag_a;
   rpn_pkg::uword_type mag_b;

   always_comb begin
      mag_a     = dividend[W-1] ? rpn_pkg::uword_type'(-dividend) : rpn_pkg::uword_type'(dividend);
      mag_b     = divisor[W-1] ? rpn_pkg::uword_type'(-divisor) : rpn_pkg::uword_type'(divisor);
      rem_shift = {rem_ff, quo_ff[W-1]};
      rem_diff  = rem_shift - {1'b0, mb_ff};
      ge        = (rem_shift >= {1'b0, mb_ff});

      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mb_in    = mb_ff;
      neg_in   = neg_ff;
      if (start) begin
         count_in = rpn_pkg::DIV_COUNT_W'(rpn_pkg::DIV_STEPS);
         rem_in   = '0;
         quo_in   = mag_a;
         mb_in    = mag_b;
         neg_in   = dividend[W-1] ^ divisor[W-1];
      end else if (count_ff != '0) begin
         count_in = count_ff - rpn_pkg::DIV_COUNT_W'(1);
         done_in  = (count_ff == rpn_pkg::DIV_COUNT_W'(1));
         rem_in   = ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
         quo_in   = {quo_ff[W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -rpn_pkg::word_type'(quo_ff) : rpn_pkg::word_type'(quo_ff);

endmodule

/* src/rpn_stack_calculator_core.sv */
// Top level of the RPN stack calculator: sequencer, operand stack as a chain of cells,
// divider and response register. Depends on rpn_pkg, rpn_req_if, rpn_rsp_if,
// rpn_cell and rpn_divider.
//
//   channel   direction   carries
//   req       in          action, operand_value
//   rsp       out         result_valid, result_value, status
//
// Push, pop, add, subtract and multiply pass from the transfer through the execute and finish states to commit;
// divide waits in the divide state between the two until the divider ends its 32 steps.
// Reset is synchronous and empties the stack; no clearing pass is needed.
// A new request is taken once the previous one has committed; commit waits while the
// response register still holds an untaken result.

module rpn_stack_calculator_core #(
   parameter int STACK_DEPTH = 8
) (
   input logic           clock,
   input logic           reset,
   rpn_req_if.sink       req,
   rpn_rsp_if.source     rsp
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   localparam logic [1:0] CMD_HOLD    = 2'd0;
   localparam logic [1:0] CMD_PUSH    = 2'd1;
   localparam logic [1:0] CMD_POP     = 2'd2;
   localparam logic [1:0] CMD_REPLACE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [DEPTH_W-1:0]  new_depth_ff, new_depth_in;
   logic [1:0]          cmd_ff, cmd_in;
   rpn_pkg::action_type act_ff, act_in;
   rpn_pkg::word_type   opnd_ff, opnd_in;
   rpn_pkg::word_type   a_ff, a_in;
   rpn_pkg::word_type   b_ff, b_in;
   rpn_pkg::word_type   res_ff, res_in;
   logic                pend_valid_ff, pend_valid_in;
   rpn_pkg::status_type pend_status_ff, pend_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_result_valid_ff, rsp_result_valid_in;
   rpn_pkg::word_type   rsp_result_value_ff, rsp_result_value_in;
   rpn_pkg::status_type rsp_status_ff, rsp_status_in;

   rpn_pkg::word_type      entries [0:STACK_DEPTH];
   rpn_pkg::cell_ctrl_type ctrl_top;
   rpn_pkg::cell_ctrl_type ctrl_rest;

   logic              div_start;
   logic              div_done;
   rpn_pkg::word_type div_quotient;

   logic commit;
   logic out_free;
   logic is_empty;
   logic is_full;
   logic has_two;

   assign entries[STACK_DEPTH] = '0;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      rpn_cell u_cell (
         .clock       (clock),
         .ctrl        ((i == 0) ? ctrl_top : ctrl_rest),
         .above_value ((i == 0) ? res_ff : entries[(i == 0) ? 0 : i - 1]),
         .below_value (entries[i + 1]),
         .value       (entries[i])
      );
   end

   rpn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign is_empty = (depth_ff == '0);
   assign is_full  = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign has_two  = (depth_ff > DEPTH_W'(1));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign commit   = (state_ff == S_FIN) && out_free;

   always_comb begin
      ctrl_top  = '0;
      ctrl_rest = '0;
      if (commit) begin
         case (cmd_ff)
            CMD_PUSH: begin
               ctrl_top.load_above  = 1'b1;
               ctrl_rest.load_above = 1'b1;
            end
            CMD_POP: begin
               ctrl_top.load_below  = 1'b1;
               ctrl_rest.load_below = 1'b1;
            end
            CMD_REPLACE: begin
               ctrl_top.load_above  = 1'b1;
               ctrl_rest.load_below = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      depth_in       = depth_ff;
      new_depth_in   = new_depth_ff;
      cmd_in         = cmd_ff;
      act_in         = act_ff;
      opnd_in        = opnd_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      res_in         = res_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      div_start      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               act_in   = req.action;
               opnd_in  = req.operand_value;
               b_in     = is_empty ? '0 : entries[0];
               a_in     = has_two ? entries[1] : '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            pend_valid_in  = 1'b0;
            pend_status_in = rpn_pkg::ST_OK;
            cmd_in         = CMD_HOLD;
            new_depth_in   = depth_ff;
            res_in         = '0;
            state_in       = S_FIN;
            case (act_ff)
               rpn_pkg::ACT_PUSH: begin
                  res_in = opnd_ff;
                  if (is_full) begin
                     pend_status_in = rpn_pkg::ST_FULL;
                  end else begin
                     cmd_in       = CMD_PUSH;
                     new_depth_in = depth_ff + DEPTH_W'(1);
                  end
               end
               rpn_pkg::ACT_POP: begin
                  pend_valid_in = 1'b1;
                  res_in        = b_ff;
                  if (is_empty) begin
                     pend_status_in = rpn_pkg::ST_EMPTY;
                  end else begin
                     cmd_in       = CMD_POP;
                     new_depth_in = depth_ff - DEPTH_W'(1);
                  end
               end
               rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL: begin
                  if (act_ff == rpn_pkg::ACT_ADD) begin
                     res_in = a_ff + b_ff;
                  end else if (act_ff == rpn_pkg::ACT_SUB) begin
                     res_in = a_ff - b_ff;
                  end else begin
                     res_in = a_ff * b_ff;
                  end
                  cmd_in       = CMD_REPLACE;
                  new_depth_in = has_two ? depth_ff - DEPTH_W'(1) : DEPTH_W'(1);
                  if (!has_two) begin
                     pend_status_in = rpn_pkg::ST_EMPTY;
                  end
               end
               rpn_pkg::ACT_DIV: begin
                  if (is_empty) begin
                     pend_status_in = rpn_pkg::ST_EMPTY;
                  end else if (b_ff == '0) begin
                     pend_status_in = rpn_pkg::ST_DIVZERO;
                  end else begin
                     div_start    = 1'b1;
                     cmd_in       = CMD_REPLACE;
                     new_depth_in = has_two ? depth_ff - DEPTH_W'(1) : DEPTH_W'(1);
                     if (!has_two) begin
                        pend_status_in = rpn_pkg::ST_EMPTY;
                     end
                     state_in = S_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_quotient;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               depth_in = new_depth_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in        = rsp_valid_ff && !rsp.ready;
      rsp_result_valid_in = rsp_result_valid_ff;
      rsp_result_value_in = rsp_result_value_ff;
      rsp_status_in       = rsp_status_ff;
      if (commit) begin
         rsp_valid_in        = 1'b1;
         rsp_result_valid_in = pend_valid_ff;
         rsp_result_value_in = pend_valid_ff ? res_ff : '0;
         rsp_status_in       = pend_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_depth_ff        <= new_depth_in;
      cmd_ff              <= cmd_in;
      act_ff              <= act_in;
      opnd_ff             <= opnd_in;
      a_ff                <= a_in;
      b_ff                <= b_in;
      res_ff              <= res_in;
      pend_valid_ff       <= pend_valid_in;
      pend_status_ff      <= pend_status_in;
      rsp_result_valid_ff <= rsp_result_valid_in;
      rsp_result_value_ff <= rsp_result_value_in;
      rsp_status_ff       <= rsp_status_in;
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_valid = rsp_result_valid_ff;
   assign rsp.result_value = rsp_result_value_ff;
   assign rsp.status       = rsp_status_ff;

endmodule
